/* rtl/rhp_pkg.sv */
// ----------------------------------------------------------------------------
// rhp_pkg
// Shared types, character codes, field codes and helper functions for the
// race heartbeat line parser.
// ----------------------------------------------------------------------------
package rhp_pkg;

    // Buffer sizes.
    localparam int LAP_DIGITS  = 5;
    localparam int TIME_DIGITS = 6;

    // Character codes.
    localparam logic [7:0] CHAR_COMMA = 8'h2C;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_G     = 8'h47;
    localparam logic [7:0] CHAR_Y     = 8'h59;
    localparam logic [7:0] CHAR_R     = 8'h52;
    localparam logic [7:0] CHAR_F     = 8'h46;

    // Field index codes within one line.
    localparam logic [2:0] FIELD_LAPS = 3'd1;
    localparam logic [2:0] FIELD_TTG  = 3'd2;
    localparam logic [2:0] FIELD_TOD  = 3'd3;
    localparam logic [2:0] FIELD_RACE = 3'd4;
    localparam logic [2:0] FIELD_FLAG = 3'd5;
    localparam logic [2:0] FIELD_LAST = 3'd7;

    // Flag state codes.
    typedef enum logic [2:0] {
        FLAG_NONE   = 3'd0,
        FLAG_GREEN  = 3'd1,
        FLAG_YELLOW = 3'd2,
        FLAG_RED    = 3'd3,
        FLAG_FINISH = 3'd4
    } flag_t;

    // Six BCD digits of one HHMMSS time, first received digit at index 0.
    typedef logic [TIME_DIGITS-1:0][3:0] digits_t;

    typedef struct packed {
        logic [6:0] hours;
        logic [6:0] minutes;
        logic [6:0] seconds;
    } hms_t;

    // One input beat as held in the input register.
    typedef struct packed {
        logic       valid;
        logic [7:0] rx_byte;
    } beat_t;

    // One result item.
    typedef struct packed {
        logic [16:0] laps_to_go;
        logic [6:0]  ttg_hours;
        logic [6:0]  ttg_minutes;
        logic [6:0]  ttg_seconds;
        logic [6:0]  tod_hours;
        logic [6:0]  tod_minutes;
        logic [6:0]  tod_seconds;
        logic [6:0]  race_hours;
        logic [6:0]  race_minutes;
        logic [6:0]  race_seconds;
        logic [2:0]  flag_state;
    } result_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    endfunction

    // Two BCD digits to binary, tens first.
    function automatic logic [6:0] two_digits(input logic [3:0] tens,
                                              input logic [3:0] ones);
        return {3'b000, tens} * 7'd10 + {3'b000, ones};
    endfunction

    function automatic hms_t pack_time(input digits_t d);
        hms_t t;
        t.hours   = two_digits(d[0], d[1]);
        t.minutes = two_digits(d[2], d[3]);
        t.seconds = two_digits(d[4], d[5]);
        return t;
    endfunction

endpackage

/* rtl/rhp_byte_if.sv */
// ----------------------------------------------------------------------------
// rhp_byte_if
// Valid/ready channel carrying one received character per beat.
// ----------------------------------------------------------------------------
interface rhp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

/* rtl/rhp_result_if.sv */
// ----------------------------------------------------------------------------
// rhp_result_if
// Valid/ready channel carrying one parsed heartbeat result per beat.
// ----------------------------------------------------------------------------
interface rhp_result_if;
    logic              valid;
    logic              ready;
    rhp_pkg::result_t  result;

    modport source (output valid, output result, input ready);
    modport sink   (input valid, input result, output ready);
endinterface

/* rtl/rhp_in_stage.sv */
// ----------------------------------------------------------------------------
// rhp_in_stage
// Input register: captures one character beat and holds it until the
// parser takes it.
// ----------------------------------------------------------------------------
module rhp_in_stage
(
    input  logic            clk,
    input  logic            rst_n,
    rhp_byte_if.sink        rx,
    input  logic            take,
    output rhp_pkg::beat_t  beat
);
    import rhp_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;
    logic       accept;

    // The register is free when empty or when its beat leaves this cycle.
    assign rx.ready = !valid_reg || take;
    assign accept   = rx.valid && rx.ready;

    always_comb
    begin
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            byte_reg <= rx.rx_byte;
        end
    end

    assign beat.valid   = valid_reg;
    assign beat.rx_byte = byte_reg;

endmodule

/* rtl/rhp_field_parser.sv */
// ----------------------------------------------------------------------------
// rhp_field_parser
// Line parser state: field index, digit buffers, latched values. One character
// per cycle is handled; a line end waits for the output and builds the result.
// ----------------------------------------------------------------------------
module rhp_field_parser
(
    input  logic              clk,
    input  logic              rst_n,
    input  rhp_pkg::beat_t    beat,
    input  logic              out_free,
    output logic              take,
    output logic              result_valid,
    output rhp_pkg::result_t  result
);
    import rhp_pkg::*;

    logic [2:0]  field_reg,     field_next;
    logic [2:0]  pos_reg,       pos_next;
    logic [2:0]  lap_count_reg, lap_count_next;
    logic [16:0] lap_acc_reg,   lap_acc_next;
    digits_t     ttg_dig_reg,   ttg_dig_next;
    digits_t     tod_dig_reg,   tod_dig_next;
    digits_t     race_dig_reg,  race_dig_next;
    logic [16:0] laps_reg,      laps_next;
    hms_t        ttg_reg,       ttg_next;
    hms_t        race_reg,      race_next;
    flag_t       flag_reg,      flag_next;

    logic [7:0]  c;
    logic        is_comma;
    logic        is_eol;
    logic        digit_ok;
    logic [3:0]  digit_val;
    logic        store_time;
    hms_t        tod_time;

    assign c         = beat.rx_byte;
    assign is_comma  = (c == CHAR_COMMA);
    assign is_eol    = (c == CHAR_LF) || (c == CHAR_CR);
    assign digit_ok  = is_digit(c);
    assign digit_val = 4'(c - CHAR_ZERO);

    // A line end needs a free output register; other beats always move on.
    assign take         = beat.valid && (!is_eol || out_free);
    assign result_valid = take && is_eol;

    // Time digits go to the current position until the buffer is full.
    assign store_time = digit_ok && (pos_reg < 3'(TIME_DIGITS));

    // Next state for one character.
    always_comb
    begin
        field_next     = field_reg;
        pos_next       = pos_reg;
        lap_count_next = lap_count_reg;
        lap_acc_next   = lap_acc_reg;
        ttg_dig_next   = ttg_dig_reg;
        tod_dig_next   = tod_dig_reg;
        race_dig_next  = race_dig_reg;
        laps_next      = laps_reg;
        ttg_next       = ttg_reg;
        race_next      = race_reg;
        flag_next      = flag_reg;

        // Separators move to the next field, saturating at the last code.
        if (is_comma)
        begin
            if (field_reg != FIELD_LAST)
            begin
                field_next = field_reg + 3'd1;
            end
            pos_next = 3'd0;
        end
        if (is_eol)
        begin
            field_next     = 3'd0;
            pos_next       = 3'd0;
            lap_count_next = 3'd0;
        end

        case (field_next)
            FIELD_LAPS:
            begin
                // The lap value is accumulated as digits arrive; a fresh
                // count restarts it.
                if (digit_ok && (lap_count_reg < 3'(LAP_DIGITS)))
                begin
                    lap_acc_next = ((lap_count_reg == 3'd0) ? 17'd0 : lap_acc_reg)
                                   * 17'd10 + {13'd0, digit_val};
                    lap_count_next = lap_count_reg + 3'd1;
                end
            end
            FIELD_TTG:
            begin
                if (lap_count_reg != 3'd0)
                begin
                    laps_next = lap_acc_reg;
                end
                if (store_time)
                begin
                    ttg_dig_next[pos_reg] = digit_val;
                    pos_next              = pos_reg + 3'd1;
                end
            end
            FIELD_TOD:
            begin
                lap_count_next = 3'd0;
                ttg_next       = pack_time(ttg_dig_reg);
                if (store_time)
                begin
                    tod_dig_next[pos_reg] = digit_val;
                    pos_next              = pos_reg + 3'd1;
                end
            end
            FIELD_RACE:
            begin
                if (store_time)
                begin
                    race_dig_next[pos_reg] = digit_val;
                    pos_next               = pos_reg + 3'd1;
                end
            end
            FIELD_FLAG:
            begin
                race_next = pack_time(race_dig_reg);
                case (c)
                    CHAR_G:  flag_next = FLAG_GREEN;
                    CHAR_Y:  flag_next = FLAG_YELLOW;
                    CHAR_R:  flag_next = FLAG_RED;
                    CHAR_F:  flag_next = FLAG_FINISH;
                    default: flag_next = flag_reg;
                endcase
            end
            default:
            begin
            end
        endcase
    end

    // State registers, updated only when a beat is taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            field_reg     <= 3'd0;
            pos_reg       <= 3'd0;
            lap_count_reg <= 3'd0;
            lap_acc_reg   <= 17'd0;
            ttg_dig_reg   <= '0;
            tod_dig_reg   <= '0;
            race_dig_reg  <= '0;
            laps_reg      <= 17'd0;
            ttg_reg       <= '0;
            race_reg      <= '0;
            flag_reg      <= FLAG_NONE;
        end
        else if (take)
        begin
            field_reg     <= field_next;
            pos_reg       <= pos_next;
            lap_count_reg <= lap_count_next;
            lap_acc_reg   <= lap_acc_next;
            ttg_dig_reg   <= ttg_dig_next;
            tod_dig_reg   <= tod_dig_next;
            race_dig_reg  <= race_dig_next;
            laps_reg      <= laps_next;
            ttg_reg       <= ttg_next;
            race_reg      <= race_next;
            flag_reg      <= flag_next;
        end
    end

    // A line end changes none of the latched values, so the result is built
    // from the current registers. Time of day is converted here.
    assign tod_time = pack_time(tod_dig_reg);

    always_comb
    begin
        result.laps_to_go   = laps_reg;
        result.ttg_hours    = ttg_reg.hours;
        result.ttg_minutes  = ttg_reg.minutes;
        result.ttg_seconds  = ttg_reg.seconds;
        result.tod_hours    = tod_time.hours;
        result.tod_minutes  = tod_time.minutes;
        result.tod_seconds  = tod_time.seconds;
        result.race_hours   = race_reg.hours;
        result.race_minutes = race_reg.minutes;
        result.race_seconds = race_reg.seconds;
        result.flag_state   = flag_reg;
    end

endmodule

/* rtl/rhp_out_stage.sv */
// ----------------------------------------------------------------------------
// rhp_out_stage
// Result register: holds one finished result until the sink takes it.
// ----------------------------------------------------------------------------
module rhp_out_stage
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  rhp_pkg::result_t  load_data,
    output logic              out_free,
    rhp_result_if.source      res
);
    import rhp_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    // Free when empty or when the held beat is taken this cycle.
    assign out_free = !valid_reg || res.ready;

    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= load_data;
        end
    end

    assign res.valid  = valid_reg;
    assign res.result = result_reg;

endmodule

/* rtl/race_heartbeat_parser.sv */
// ----------------------------------------------------------------------------
// race_heartbeat_parser
// Parses a comma-separated timing heartbeat line one character at a time and
// emits one result with laps, times and flag at each CR or LF.
//
//   Port   | Dir | Beat carries
//   -------+-----+----------------------------------------------
//   rx     | in  | rx_byte: one ASCII character
//   res    | out | result: laps, three HMS times, flag state
//
// One character can be accepted every cycle. A CR or LF is held in the input
// register, and the combinational parser loads its result from there into
// the result register, which then presents it as valid. Reset clears the
// field state, digit buffers and latched values. A stalled result register
// holds up only a line end: it waits in the input register and the input
// stalls behind it, while other characters pass the parser regardless.
// ----------------------------------------------------------------------------
module race_heartbeat_parser
(
    input  logic          clk,
    input  logic          rst_n,
    rhp_byte_if.sink      rx,
    rhp_result_if.source  res
);
    import rhp_pkg::*;

    beat_t   beat;
    logic    take;
    logic    out_free;
    logic    result_valid;
    result_t result;

    // Input register.
    rhp_in_stage u_in_stage
    (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx),
        .take  (take),
        .beat  (beat)
    );

    // Field parsing and latched values.
    rhp_field_parser u_field_parser
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .beat         (beat),
        .out_free     (out_free),
        .take         (take),
        .result_valid (result_valid),
        .result       (result)
    );

    // Result register.
    rhp_out_stage u_out_stage
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (result_valid),
        .load_data (result),
        .out_free  (out_free),
        .res       (res)
    );

endmodule

/* rtl/rhp_checker.sv */
// ----------------------------------------------------------------------------
// rhp_checker
// Port-level checks for the heartbeat parser, bound to the top level.
// ----------------------------------------------------------------------------
module rhp_checker
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rx_valid,
    input  logic              rx_ready,
    input  logic [7:0]        rx_byte,
    input  logic              res_valid,
    input  logic              res_ready,
    input  rhp_pkg::result_t  result
);
    import rhp_pkg::*;

    // A new result only follows a line end accepted by the input register.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |->
            $past(rx_valid && rx_ready && (rx_byte == CHAR_CR || rx_byte == CHAR_LF), 2))
    else $error("result appeared without a preceding line end");

    // A stalled result beat holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(result))
    else $error("stalled result beat changed");

    // Lap count and flag stay within their ranges.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (result.laps_to_go <= 17'd99999) &&
                      (result.flag_state <= 3'd4))
    else $error("lap count or flag out of range");

    // Every minute and second field is a two-digit value.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (result.ttg_minutes <= 7'd99) && (result.ttg_seconds <= 7'd99) &&
                      (result.tod_minutes <= 7'd99) && (result.tod_seconds <= 7'd99) &&
                      (result.race_minutes <= 7'd99) && (result.race_seconds <= 7'd99))
    else $error("time field out of range");

endmodule

bind race_heartbeat_parser rhp_checker u_rhp_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .rx_valid  (rx.valid),
    .rx_ready  (rx.ready),
    .rx_byte   (rx.rx_byte),
    .res_valid (res.valid),
    .res_ready (res.ready),
    .result    (res.result)
);
